@@ rtl/b64e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the character table of the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       run_last;
    logic       message_done;
  } out_req_t;

  // one group handed from front to back
  typedef struct packed {
    logic [23:0] bits;   // bytes msb first, zero filled
    logic [1:0]  pad;    // number of '=' characters
    logic        done;   // group closes the message
  } group_t;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  localparam logic [1:0] CHAR_LAST = 2'd3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

@@ rtl/base64_stream_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// usage
//   input channel: one raw byte per request, message_end set on the last
//   byte of a message. output channel: one ascii character per request,
//   run_last on the fourth character of each group, message_done on the
//   final character of a message.
//   the front gathers bytes into groups of three; a full group, or a partial
//   group closed by message_end, goes into a short queue (QUEUE_DEPTH groups)
//   and the back emits its four characters, one per cycle unless the receiver stalls.
//   the first character of a group passes through the queue and then the
//   output register once the byte that closes the group is accepted; the
//   other three follow on consecutive cycles unless the receiver stalls.
//   throughput: bytes are taken one per cycle until the queue fills; the
//   single character output port sets the sustained rate at four characters
//   per group, and also four characters for a padded group.
//   reset clears the byte phase, empties the queue and drops out_valid.
//   a stalled receiver holds the output character; the back waits, the
//   queue fills, and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  b64e_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output b64e_pkg::out_req_t out_data
);
  import b64e_pkg::*;

  // front to queue
  logic   q_push;
  group_t q_wdata;
  logic   q_full;
  // queue to back
  logic   q_pop;
  group_t q_head;
  logic   q_nempty;

  // byte gathering and grouping
  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // decouples byte intake from character output
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .nempty    (q_nempty)
  );

  // character generation, registered output
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/b64e_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// gathers bytes into groups of three and hands finished groups to the queue
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  b64e_pkg::in_req_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output b64e_pkg::group_t  q_data
);
  import b64e_pkg::*;

  logic [1:0] phase;
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic       accept;
  logic [1:0] ph;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // unreachable phase 3 behaves as empty
  assign ph = (phase == PHASE_ONE || phase == PHASE_TWO) ? phase : PHASE_NONE;

  always_comb begin
    q_data.done = in_data.message_end;
    case (ph)
      PHASE_ONE: begin
        q_data.bits = {held_first, in_data.data_byte, 8'h00};
        q_data.pad  = PAD_ONE;
        q_push      = accept && in_data.message_end;
      end
      PHASE_TWO: begin
        q_data.bits = {held_first, held_second, in_data.data_byte};
        q_data.pad  = PAD_NONE;
        q_push      = accept;
      end
      default: begin
        q_data.bits = {in_data.data_byte, 16'h0000};
        q_data.pad  = PAD_TWO;
        q_push      = accept && in_data.message_end;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_NONE;
    end else if (accept) begin
      if (q_push) begin
        phase <= PHASE_NONE;
      end else begin
        phase <= ph + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ph == PHASE_NONE) begin
      held_first <= in_data.data_byte;
    end
    if (accept && ph == PHASE_ONE) begin
      held_second <= in_data.data_byte;
    end
  end

endmodule

@@ rtl/b64e_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_fifo
// short group queue between front and back
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64e_pkg::group_t push_data,
  input  logic             pop,
  output b64e_pkg::group_t head,
  output logic             full,
  output logic             nempty
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == CW'(DEPTH));
  assign nempty = (count != '0);
  assign head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("group queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nempty)
    else $error("group queue read while empty");
`endif

endmodule

@@ rtl/b64e_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// expands one queued group into four characters through an output register
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nempty,
  input  b64e_pkg::group_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output b64e_pkg::out_req_t out_data
);
  import b64e_pkg::*;

  group_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic       advance;
  logic       produce;
  group_t     sel;
  logic [1:0] sel_idx;
  logic [5:0] sextet;
  logic [2:0] pad_sum;
  out_req_t   char_next;

  assign advance = !out_valid || !out_stall;
  assign produce = advance && (busy || q_nempty);
  assign q_pop   = produce && !busy;

  assign sel     = busy ? cur : q_head;
  assign sel_idx = busy ? idx : 2'd0;

  always_comb begin
    case (sel_idx)
      2'd0:    sextet = sel.bits[23:18];
      2'd1:    sextet = sel.bits[17:12];
      2'd2:    sextet = sel.bits[11:6];
      default: sextet = sel.bits[5:0];
    endcase
  end

  // positions at or past four minus the pad count are '='
  assign pad_sum = {1'b0, sel_idx} + {1'b0, sel.pad};

  always_comb begin
    char_next.text_char    = (pad_sum >= 3'd4) ? PAD_CHAR : sextet_char(sextet);
    char_next.run_last     = (sel_idx == CHAR_LAST);
    char_next.message_done = (sel_idx == CHAR_LAST) && sel.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= produce;
      end
      if (produce) begin
        if (!busy) begin
          busy <= 1'b1;
          idx  <= 2'd1;
        end else if (idx == CHAR_LAST) begin
          busy <= 1'b0;
          idx  <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (produce) begin
      out_data <= char_next;
    end
  end

`ifndef SYNTHESIS
  a_busy_idx: assert property (@(posedge clk) disable iff (rst) busy |-> idx != 2'd0)
    else $error("group in progress with character index zero");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.message_done |-> out_data.run_last)
    else $error("message end flagged on a non-final character");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the base64 stream encoder against a cycle-free predictor: directed
// messages hit every padding case and the alphabet ends, then random
// messages run with random sender gaps and receiver stalls, with one stretch
// at full rate; every character is compared in order against the predicted
// characters and flags
// ----------------------------------------------------------------------------
module testbench;
  import b64e_pkg::*;

  // alphabet packed msb first, letter v sits at bits [8*(63-v) +: 8]
  localparam logic [8*64-1:0] B64_LETTERS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  // cycles with no handshake on either side before the run is called hung
  localparam int HANG_LIMIT = 2000;
  // quiet cycles after the last character, to catch stray output
  localparam int DRAIN_CYCLES = 12;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;

  // random gaps and stalls are on unless a test asks for a full-rate stretch
  logic idling_on = 1'b1;

  // predictor state: bytes waiting for their group to fill
  logic [7:0] pend_first = '0;
  logic [7:0] pend_second = '0;
  logic [1:0] pend_count = PHASE_NONE;

  // characters predicted but not yet seen on the output
  out_req_t expected_chars[$];

  int bytes_sent = 0;
  int messages_sent = 0;
  int chars_checked = 0;
  int mismatch_count = 0;
  int one_byte_tails = 0;
  int two_byte_tails = 0;
  int full_groups = 0;
  int quiet_cycles = 0;

  base64_stream_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  function automatic logic [7:0] letter_of(input logic [5:0] v);
    int idx;
    idx = 63 - int'(v);
    return B64_LETTERS[idx*8 +: 8];
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last, input logic done);
    out_req_t r;
    r.text_char = c;
    r.run_last = last;
    r.message_done = done;
    expected_chars.push_back(r);
  endtask

  // one accepted byte: either held, or it closes a group and yields four chars
  task automatic predict_byte(input logic [7:0] b, input logic e);
    case (pend_count)
      PHASE_ONE: begin
        if (!e) begin
          pend_second = b;
          pend_count = PHASE_TWO;
        end else begin
          // two bytes close the message: three letters and one pad
          push_char(letter_of(pend_first[7:2]), 1'b0, 1'b0);
          push_char(letter_of({pend_first[1:0], b[7:4]}), 1'b0, 1'b0);
          push_char(letter_of({b[3:0], 2'b00}), 1'b0, 1'b0);
          push_char(PAD_CHAR, 1'b1, 1'b1);
          pend_count = PHASE_NONE;
          two_byte_tails++;
        end
      end
      PHASE_TWO: begin
        // third byte always completes the group, message_end or not
        push_char(letter_of(pend_first[7:2]), 1'b0, 1'b0);
        push_char(letter_of({pend_first[1:0], pend_second[7:4]}), 1'b0, 1'b0);
        push_char(letter_of({pend_second[3:0], b[7:6]}), 1'b0, 1'b0);
        push_char(letter_of(b[5:0]), 1'b1, e);
        pend_count = PHASE_NONE;
        full_groups++;
      end
      default: begin
        if (!e) begin
          pend_first = b;
          pend_count = PHASE_ONE;
        end else begin
          // a lone final byte: two letters and two pads
          push_char(letter_of(b[7:2]), 1'b0, 1'b0);
          push_char(letter_of({b[1:0], 4'b0000}), 1'b0, 1'b0);
          push_char(PAD_CHAR, 1'b0, 1'b0);
          push_char(PAD_CHAR, 1'b1, 1'b1);
          pend_count = PHASE_NONE;
          one_byte_tails++;
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // offer one byte and hold it until the encoder takes it; valid stays high
  // for a following byte unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 2);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, message_end: e};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, e);
    bytes_sent++;
    if (e) messages_sent++;
  endtask

  // random bytes, with the extremes drawn more often than chance
  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(random_byte(), i == len - 1);
    end
  endtask

  // messages of random length until about n_bytes have gone in; most are
  // short so every tail case shows up often, a few span many groups
  task automatic send_random_messages(input int n_bytes);
    int start;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(10, 40);
      else len = $urandom_range(1, 9);
      send_message(len);
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // lone final byte, padded with two '='
  task automatic test_one_byte_tail();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // two-byte message, padded with one '='
  task automatic test_two_byte_tail();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // whole groups: a textbook word, both top letters, a group that does not
  // end the message, and a message that ends mid-group after a full one
  task automatic test_full_groups();
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    idling_on <= 1'b1;
    send_random_messages(n_bytes);
  endtask

  // full rate on both sides, so the queue inside fills and in_stall rises;
  // the following random test turns idling back on
  task automatic test_back_to_back(input int n_bytes);
    idling_on <= 1'b0;
    send_random_messages(n_bytes);
  endtask

  // ------------------------------------------------------------------------
  // result side: compare each accepted character, then draw the next stall
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    out_req_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected character %h last %b done %b at %0t",
                   out_data.text_char, out_data.run_last, out_data.message_done, $time);
        end
      end else begin
        want = expected_chars.pop_front();
        if (out_data.text_char !== want.text_char ||
            out_data.run_last !== want.run_last ||
            out_data.message_done !== want.message_done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t: expected char %h last %b done %b, got char %h last %b done %b",
                     $time, want.text_char, want.run_last, want.message_done,
                     out_data.text_char, out_data.run_last, out_data.message_done);
          end
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idling_on && ($urandom_range(0, 99) < 8);
    end
  end

  // ------------------------------------------------------------------------
  // hang watchdog: no request moved on either side for too long
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", HANG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_one_byte_tail();
    test_two_byte_tail();
    test_full_groups();
    test_random_traffic(180);
    test_back_to_back(120);
    test_random_traffic(140);

    // every message above ends, so all groups flush
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $display("%0d predicted characters never arrived", expected_chars.size());
    end
    $display("sent %0d bytes in %0d messages, checked %0d characters, %0d mismatches",
             bytes_sent, messages_sent, chars_checked, mismatch_count);
    $display("groups: %0d full, %0d one-byte tails, %0d two-byte tails",
             full_groups, one_byte_tails, two_byte_tails);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
tb/sv/testbench.sv
